/* rtl/core/tcpq_pkg.sv */
`timescale 1ns / 1ps

package tcpq_pkg;

    localparam int DEPTH     = 16;
    localparam int MSG_WIDTH = 32;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam int CMD_W    = 2;
    localparam int MSGF_W   = 32;
    localparam int SIZE_W   = 8;
    localparam int STAT_W   = 2;
    localparam int OCNT_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 8;

    localparam int IN_BITS   = CMD_W + MSGF_W + SIZE_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STAT_W + MSGF_W + 2 * OCNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_PUT_NORMAL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT_PRIO   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET        = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP        = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_LONG  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd1;

    localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 8'd15;
    localparam logic [CAP_W-1:0]  CAPACITY_RST = 5'd16;

    typedef struct packed {
        logic exec;
        logic hold;
    } t_dp_cmd;

    typedef struct packed {
        logic [OCNT_W-1:0] priority_count;
        logic [OCNT_W-1:0] count;
        logic [MSGF_W-1:0] message_out;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

/* rtl/core/tcpq_ctrl.sv */
`timescale 1ns / 1ps

module tcpq_ctrl
    import tcpq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_dp_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;

    logic r_state;
    logic n_state;
    logic exec;

    // result register frees up in the same cycle it is taken
    assign o_s_tready = (r_state == S_IDLE) || i_m_tready;
    assign o_m_tvalid = (r_state == S_HOLD);
    assign exec       = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (exec) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_m_tready && !exec) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.exec = exec;
    assign o_cmd.hold = (r_state == S_HOLD) && !i_m_tready;

    a_exec_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> r_state == S_HOLD)
        else $error("accepted item left no result");

    a_no_load_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.hold |-> !o_cmd.exec)
        else $error("new item taken over a waiting result");

endmodule

/* rtl/core/tcpq_dp.sv */
`timescale 1ns / 1ps

module tcpq_dp
    import tcpq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [CMD_W-1:0]     i_op,
    input  logic [MSGF_W-1:0]    i_message,
    input  logic [SIZE_W-1:0]    i_msg_len,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_result              o_result
);

    logic [MSG_WIDTH-1:0] r_slots [DEPTH];
    logic [MSG_WIDTH-1:0] n_slots [DEPTH];
    logic [CNT_W-1:0]     r_occ;
    logic [CNT_W-1:0]     n_occ;
    logic [CNT_W-1:0]     r_pf;
    logic [CNT_W-1:0]     n_pf;
    logic [SIZE_W-1:0]    r_max_size;
    logic [CAP_W-1:0]     r_capacity;
    t_result              r_result;

    logic                 is_put;
    logic                 too_long;
    logic                 full;
    logic [STAT_W-1:0]    status;
    logic [MSG_WIDTH-1:0] popped;
    logic [MSG_WIDTH-1:0] msg;
    logic                 do_norm;
    logic                 do_prio;
    logic                 do_get;

    assign msg      = MSG_WIDTH'(i_message);
    assign is_put   = (i_op == CMD_PUT_NORMAL) || (i_op == CMD_PUT_PRIO);
    assign too_long = i_msg_len > r_max_size;
    assign full     = (CMP_W'(r_occ) >= CMP_W'(r_capacity)) || (r_occ >= CNT_W'(DEPTH));

    always_comb begin
        status  = ST_OK;
        popped  = '0;
        do_norm = 1'b0;
        do_prio = 1'b0;
        do_get  = 1'b0;
        if (is_put) begin
            priority if (too_long) begin
                status = ST_LONG;
            end else if (full) begin
                status = ST_FULL;
            end else if (i_op == CMD_PUT_NORMAL) begin
                do_norm = 1'b1;
            end else begin
                do_prio = 1'b1;
            end
        end else if (i_op == CMD_GET) begin
            if (r_occ == '0) begin
                status = ST_EMPTY;
            end else begin
                do_get = 1'b1;
                popped = r_slots[0];
            end
        end
    end

    always_comb begin
        n_occ = r_occ;
        n_pf  = r_pf;
        if (do_norm) begin
            n_occ = r_occ + 1'b1;
        end else if (do_prio) begin
            n_occ = r_occ + 1'b1;
            n_pf  = r_pf + 1'b1;
        end else if (do_get) begin
            n_occ = r_occ - 1'b1;
            if (r_pf != '0) begin
                n_pf = r_pf - 1'b1;
            end
        end
    end

    // all slots move in parallel
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_slots[i] = r_slots[i];
        end
        if (do_get) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_slots[i] = r_slots[i + 1];
            end
        end else if (do_norm) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (CNT_W'(i) == r_occ) begin
                    n_slots[i] = msg;
                end
            end
        end else if (do_prio) begin
            for (int i = 1; i < DEPTH; i++) begin
                if ((CNT_W'(i) > r_pf) && (CNT_W'(i) <= r_occ)) begin
                    n_slots[i] = r_slots[i - 1];
                end
            end
            for (int i = 0; i < DEPTH; i++) begin
                if (CNT_W'(i) == r_pf) begin
                    n_slots[i] = msg;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_slots[i] <= n_slots[i];
            end
            r_result.status         <= status;
            r_result.message_out    <= MSGF_W'(popped);
            r_result.count          <= OCNT_W'(n_occ);
            r_result.priority_count <= OCNT_W'(n_pf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ      <= '0;
            r_pf       <= '0;
            r_max_size <= MAX_SIZE_RST;
            r_capacity <= CAPACITY_RST;
        end else begin
            if (i_cmd.exec) begin
                r_occ <= n_occ;
                r_pf  <= n_pf;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_SIZE: r_max_size <= i_cfg_wdata;
                    CFG_CAPACITY: r_capacity <= CAP_W'(i_cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

    assign o_result = r_result;

    a_pf_le_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pf <= r_occ) && (r_occ <= CNT_W'(DEPTH)))
        else $error("fill counters out of order");

    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (do_norm || do_prio) |=> r_occ == $past(r_occ) + 1'b1)
        else $error("put did not grow the queue");

    a_refused_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (status != ST_OK) |=> $stable(r_occ) && $stable(r_pf))
        else $error("refused item changed the queue");

endmodule

/* rtl/core/two_class_priority_queue.sv */
`timescale 1ns / 1ps
// channel   dir  signals                          contents
// s         in   i_s_tvalid/o_s_tready/i_s_tdata  cmd, message, msg_len
// m         out  o_m_tvalid/i_m_tready/o_m_tdata  status, message_out, count, priority_count
// cfg       in   i_cfg_we/i_cfg_idx/i_cfg_wdata   0 max_entry_size, 1 capacity
//
// one item per cycle while no result is stalled: the shift register slots are updated in the cycle an item is taken
// the result is registered at the input transfer and appears in the cycle after it
// a stalled result holds the input side; it is taken again in the cycle the result leaves
// reset: synchronous, empty queue, max_entry_size 15, capacity 16, no clearing pass

module two_class_priority_queue
    import tcpq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // cmd, message, msg_len
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // status, message_out, count, priority_count
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    t_dp_cmd dp_cmd;
    t_result result;

    tcpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (dp_cmd)
    );

    tcpq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_op           (i_s_tdata[CMD_W-1:0]),
        .i_message      (i_s_tdata[CMD_W +: MSGF_W]),
        .i_msg_len      (i_s_tdata[CMD_W + MSGF_W +: SIZE_W]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result       (result)
    );

    assign o_m_tdata = OUT_TDATA_W'(result);

endmodule
